// File: src/pbci_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbci_pkg
// Shared types and constants for the pixel brightness / contrast / invert unit.
// ----------------------------------------------------------------------------
package pbci_pkg;

    localparam int PIX_W                 = 8;
    localparam int TDATA_W               = 32;
    localparam int CFG_ADDR_W            = 2;
    localparam int CFG_DATA_W            = 8;
    localparam int NUM_LANES             = 3;
    localparam int DEF_FACTOR_FRAC_BITS  = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_ADDR_W-1:0] REG_BRIGHTNESS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_CONTRAST   = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERT     = 2'd2;

    // floor(t / 25) == (t * DIV25_MUL) >> DIV25_SHIFT for every 13-bit t up to 6375.
    localparam logic [12:0] DIV25_MUL   = 13'd5243;
    localparam int          DIV25_SHIFT = 17;

    // Per-stage advance strobes of the lane pipeline.
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } stage_en_t;

    // Brightness terms shared by all lanes: y = (base + x * scale) / 200.
    typedef struct packed {
        logic [14:0] base;
        logic [7:0]  scale;
    } bright_t;

    // Saturate a signed percent setting to -100..100.
    function automatic logic signed [7:0] sat_pct(input logic signed [7:0] v);
        logic signed [7:0] r;
        r = v;
        if (v > 8'sd100) begin
            r = 8'sd100;
        end else if (v < -8'sd100) begin
            r = -8'sd100;
        end
        return r;
    endfunction

endpackage

// File: src/pbci_factor_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbci_factor_div
// Restoring divider that forms the contrast factor 259(c+100)/(25900-255c)
// in unsigned fixed point, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pbci_factor_div #(
    parameter int FACTOR_FRAC_BITS = pbci_pkg::DEF_FACTOR_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [pbci_pkg::CFG_DATA_W-1:0]     contrast,
    output logic [FACTOR_FRAC_BITS+7:0]         factor,
    output logic                                factor_valid
);
    import pbci_pkg::*;

    localparam int FW = FACTOR_FRAC_BITS + 8;
    localparam int CW = $clog2(FW + 1);

    logic                 busy_reg, busy_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic [15:0]          rem_reg, rem_next;
    logic [FW-1:0]        dvd_reg, dvd_next;
    logic [FW-1:0]        quo_reg, quo_next;
    logic [15:0]          den_reg, den_next;
    logic [FW-1:0]        factor_reg, factor_next;

    logic signed [7:0]    c_sat;
    logic [7:0]           c_plus;
    logic [7:0]           c_minus;
    logic [15:0]          num;
    logic [16:0]          trial;
    logic                 qbit;

    always_comb begin
        c_sat   = sat_pct($signed(contrast));
        c_plus  = 8'($signed({c_sat[7], c_sat}) + 9'sd100);
        c_minus = 8'(8'd200 - c_plus);
        num     = 16'(c_plus) * 16'd259;

        trial = {rem_reg, dvd_reg[FW-1]};
        qbit  = (trial >= {1'b0, den_reg});

        busy_next   = busy_reg;
        cnt_next    = cnt_reg;
        rem_next    = rem_reg;
        dvd_next    = dvd_reg;
        quo_next    = quo_reg;
        den_next    = den_reg;
        factor_next = factor_reg;

        if (start) begin
            // The numerator's top byte is always below the divisor, so it
            // seeds the remainder and only FW quotient bits remain.
            busy_next = 1'b1;
            cnt_next  = CW'(FW);
            rem_next  = {8'd0, num[15:8]};
            dvd_next  = {num[7:0], {FACTOR_FRAC_BITS{1'b0}}};
            quo_next  = '0;
            den_next  = 16'(c_minus) * 16'd255 + 16'd400;
        end else if (busy_reg) begin
            rem_next = qbit ? 16'(trial - {1'b0, den_reg}) : trial[15:0];
            dvd_next = {dvd_reg[FW-2:0], 1'b0};
            quo_next = {quo_reg[FW-2:0], qbit};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next   = 1'b0;
                factor_next = quo_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg   <= 1'b0;
            cnt_reg    <= '0;
            factor_reg <= FW'(1) << FACTOR_FRAC_BITS;
        end else begin
            busy_reg   <= busy_next;
            cnt_reg    <= cnt_next;
            factor_reg <= factor_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
    end

    assign factor       = factor_reg;
    assign factor_valid = !busy_reg;

endmodule

// File: src/pbci_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbci_lane
// One color channel: brightness blend, divide by 200, contrast product.
// ----------------------------------------------------------------------------
module pbci_lane #(
    parameter int FACTOR_FRAC_BITS = pbci_pkg::DEF_FACTOR_FRAC_BITS
) (
    input  logic                                aclk,
    input  pbci_pkg::stage_en_t                 en,
    input  logic [pbci_pkg::PIX_W-1:0]          pix_in,
    input  pbci_pkg::bright_t                   bright,
    input  logic [FACTOR_FRAC_BITS+7:0]         factor,
    output logic signed [FACTOR_FRAC_BITS+18:0] prod_out
);
    import pbci_pkg::*;

    localparam int FW = FACTOR_FRAC_BITS + 8;
    localparam int PW = FW + 11;

    logic [15:0]          sum_reg, sum_next;
    logic [7:0]           y_reg, y_next;
    logic signed [PW-1:0] prod_reg, prod_next;

    logic [12:0]          sum_div8;
    logic [25:0]          recip;
    logic signed [FW:0]   factor_s;
    logic signed [8:0]    centered;

    always_comb begin
        sum_next = 16'(bright.base) + 16'(pix_in) * 16'(bright.scale);

        // sum / 200 == (sum / 8) / 25
        sum_div8 = sum_reg[15:3];
        recip    = 26'(sum_div8) * 26'(DIV25_MUL);
        y_next   = 8'(recip >> DIV25_SHIFT);

        factor_s  = $signed({1'b0, factor});
        centered  = $signed({1'b0, y_reg}) - 9'sd128;
        prod_next = PW'(factor_s) * PW'(centered);
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            sum_reg <= sum_next;
        end
        if (en.s2) begin
            y_reg <= y_next;
        end
        if (en.s3) begin
            prod_reg <= prod_next;
        end
    end

    assign prod_out = prod_reg;

endmodule

// File: src/pbci_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbci_merge
// Finishes the contrast step of every lane (offset, clamp, invert), joins
// the channels with alpha (or 255) and holds the result in the output register.
// ----------------------------------------------------------------------------
module pbci_merge #(
    parameter int FACTOR_FRAC_BITS = pbci_pkg::DEF_FACTOR_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en_out,
    input  logic                                in_valid,
    input  logic signed [FACTOR_FRAC_BITS+18:0] prod [pbci_pkg::NUM_LANES],
    input  logic [pbci_pkg::PIX_W-1:0]          alpha,
    input  logic                                neutral,
    input  logic                                invert,
    output logic                                m_tvalid,
    output logic [pbci_pkg::TDATA_W-1:0]        m_tdata
);
    import pbci_pkg::*;

    localparam int FW = FACTOR_FRAC_BITS + 8;
    localparam int PW = FW + 11;
    localparam logic signed [PW-1:0] BIAS = PW'(128) <<< FACTOR_FRAC_BITS;
    localparam logic signed [PW-1:0] TOP  = PW'(255) <<< FACTOR_FRAC_BITS;

    logic                     valid_reg;
    logic [TDATA_W-1:0]       data_reg, data_next;
    logic signed [PW-1:0]     level [NUM_LANES];
    logic [PIX_W-1:0]         chan  [NUM_LANES];

    always_comb begin
        for (int i = 0; i < NUM_LANES; i++) begin
            level[i] = prod[i] + BIAS;
            if (level[i] < 0) begin
                chan[i] = '0;
            end else if (level[i] >= TOP) begin
                chan[i] = 8'd255;
            end else begin
                chan[i] = level[i][FACTOR_FRAC_BITS +: PIX_W];
            end
            if (invert) begin
                chan[i] = 8'd255 - chan[i];
            end
        end
        // With neutral settings the color path is an identity; only alpha differs.
        data_next = {chan[2], chan[1], chan[0], (neutral ? alpha : 8'd255)};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en_out) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

// File: src/pixel_brightness_contrast_invert_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_brightness_contrast_invert_unit
// Adjusts brightness and contrast of an ARGB pixel stream and optionally
// inverts the color channels.
// ----------------------------------------------------------------------------
// Usage:
// Pixels enter on the s_ stream and leave on the m_ stream, one result per
// input, in order. Red, green and blue run in three parallel lanes; the
// merge stage clamps, inverts and rejoins them with alpha.
// Each pixel passes four register stages, the first loaded at the transfer
// edge, before m_tvalid; while m_tready stays high and no divide runs, the
// unit takes one pixel per clock. Each pipeline stage advances when the
// stage after it is empty or moving, so bubbles are squeezed out and input
// is still taken while a finished pixel waits on m_tready.
// Settings are written through cfg_we/cfg_addr/cfg_wdata while the stream is
// idle. A write to contrast starts the factor divider, which works out
// FACTOR_FRAC_BITS + 8 quotient bits (24 at the default); s_tready stays low
// until it finishes.
// Reset clears the settings to neutral, sets the factor to one and empties
// the pipeline. When the receiver stalls, the output register holds its
// transfer and the stages behind it fill up before s_tready drops.
// ----------------------------------------------------------------------------
module pixel_brightness_contrast_invert_unit #(
    parameter int FACTOR_FRAC_BITS = pbci_pkg::DEF_FACTOR_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // Input stream
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pbci_pkg::TDATA_W-1:0]        s_tdata,   // alpha_in, red_in, green_in, blue_in
    // Result stream
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pbci_pkg::TDATA_W-1:0]        m_tdata,   // alpha_out, red_out, green_out, blue_out
    // Configuration
    input  logic                                cfg_we,
    input  logic [pbci_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pbci_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import pbci_pkg::*;

    localparam int FW = FACTOR_FRAC_BITS + 8;
    localparam int PW = FW + 11;

    logic signed [7:0]    brightness_reg;
    logic signed [7:0]    contrast_reg;
    logic                 invert_reg;

    logic                 v1_reg, v2_reg, v3_reg;
    logic [PIX_W-1:0]     a1_reg, a2_reg, a3_reg;

    stage_en_t            en;
    logic                 en_out;
    logic                 s_fire;
    logic                 factor_valid;
    logic [FW-1:0]        factor;
    logic                 div_start;
    logic                 neutral;

    logic signed [7:0]    b_sat;
    logic [6:0]           b_mag;
    bright_t              bright;

    logic signed [PW-1:0] prod [NUM_LANES];

    // Settings
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            brightness_reg <= '0;
            contrast_reg   <= '0;
            invert_reg     <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_BRIGHTNESS: brightness_reg <= $signed(cfg_wdata);
                REG_CONTRAST:   contrast_reg   <= $signed(cfg_wdata);
                REG_INVERT:     invert_reg     <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign div_start = cfg_we && (cfg_addr == REG_CONTRAST);
    assign neutral   = (brightness_reg == 8'sd0) && (contrast_reg == 8'sd0) && !invert_reg;

    always_comb begin
        b_sat        = sat_pct(brightness_reg);
        b_mag        = b_sat[7] ? 7'(-b_sat) : 7'(b_sat);
        bright.scale = 8'(8'd200 - 8'(b_mag));
        bright.base  = (b_sat > 8'sd0) ? 15'(b_mag) * 15'd255 : 15'd0;
    end

    // Pipeline control
    always_comb begin
        en_out   = !m_tvalid || m_tready;
        en.s3    = !v3_reg || en_out;
        en.s2    = !v2_reg || en.s3;
        en.s1    = !v1_reg || en.s2;
        s_tready = en.s1 && factor_valid;
        s_fire   = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (en.s1) begin
                v1_reg <= s_fire;
            end
            if (en.s2) begin
                v2_reg <= v1_reg;
            end
            if (en.s3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            a1_reg <= s_tdata[PIX_W-1:0];
        end
        if (en.s2) begin
            a2_reg <= a1_reg;
        end
        if (en.s3) begin
            a3_reg <= a2_reg;
        end
    end

    pbci_factor_div #(
        .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .start        (div_start),
        .contrast     (cfg_wdata),
        .factor       (factor),
        .factor_valid (factor_valid)
    );

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        pbci_lane #(
            .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
        ) u_lane (
            .aclk     (aclk),
            .en       (en),
            .pix_in   (s_tdata[(g+1)*PIX_W +: PIX_W]),
            .bright   (bright),
            .factor   (factor),
            .prod_out (prod[g])
        );
    end

    pbci_merge #(
        .FACTOR_FRAC_BITS (FACTOR_FRAC_BITS)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en_out   (en_out),
        .in_valid (v3_reg),
        .prod     (prod),
        .alpha    (a3_reg),
        .neutral  (neutral),
        .invert   (invert_reg),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata)
    );

endmodule

// File: src/pbci_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbci_checker
// Port-level checks for the pixel brightness / contrast / invert unit.
// ----------------------------------------------------------------------------
module pbci_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tready,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [pbci_pkg::TDATA_W-1:0]     m_tdata,
    input  logic                             cfg_we,
    input  logic [pbci_pkg::CFG_ADDR_W-1:0]  cfg_addr
);
    import pbci_pkg::*;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A stalled result holds its transfer.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // A new contrast value blocks input until the factor is recomputed.
    a_contrast_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && (cfg_addr == REG_CONTRAST) |=> !s_tready)
        else $error("input accepted right after a contrast write");

    // Right after reset, with nothing in flight and the factor ready, input is not refused.
    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> s_tready)
        else $error("input not ready right after reset");

endmodule

bind pixel_brightness_contrast_invert_unit pbci_checker u_pbci_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr)
);

// File: dv/pixel_adjust_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_adjust_checker
// Watches the configuration port and both pixel streams of the brightness,
// contrast and invert unit. It keeps its own copy of the settings and of the
// fixed-point contrast factor, and predicts every adjusted pixel. It then
// compares each result transfer field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module pixel_adjust_checker #(
    parameter int FRAC_BITS = pbci_pkg::DEF_FACTOR_FRAC_BITS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic [pbci_pkg::TDATA_W-1:0]        s_tdata,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [pbci_pkg::TDATA_W-1:0]        m_tdata,
    input  logic                                cfg_we,
    input  logic [pbci_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [pbci_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    output int                                  mismatches,
    output int                                  in_flight
);
    import pbci_pkg::*;

    localparam int FACTOR_W = 8 + FRAC_BITS;

    // Alpha sits in the lowest byte of tdata.
    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
        logic [7:0] alpha;
    } pixel_t;

    logic signed [7:0]     brightness_set;
    logic signed [7:0]     contrast_set;
    logic                  invert_set;
    logic [FACTOR_W-1:0]   factor;
    logic                  factor_stale;
    pixel_t                expected_pixels[$];

    function automatic int pct_clamp(input logic signed [7:0] v);
        int r;
        r = v;
        if (r > 100) begin
            r = 100;
        end else if (r < -100) begin
            r = -100;
        end
        return r;
    endfunction

    function automatic logic [FACTOR_W-1:0] factor_for(input logic signed [7:0] c_raw);
        longint c;
        longint num;
        longint den;
        c   = pct_clamp(c_raw);
        num = longint'(259 * (c + 100)) << FRAC_BITS;
        den = 25900 - 255 * c;
        return FACTOR_W'(num / den);
    endfunction

    // Blend toward white for positive brightness, toward black for negative.
    function automatic logic [7:0] brighten_channel(input logic [7:0] x);
        int b;
        int mag;
        int base;
        b    = pct_clamp(brightness_set);
        mag  = (b < 0) ? -b : b;
        base = (b > 0) ? 255 * mag : 0;
        return 8'((base + int'(x) * (200 - mag)) / 200);
    endfunction

    // Scale around mid-grey with the truncated factor, then clamp and floor.
    function automatic logic [7:0] stretch_channel(input logic [7:0] y);
        longint one;
        longint t;
        one = longint'(1) << FRAC_BITS;
        t   = longint'(factor) * (longint'(y) - 128) + 128 * one;
        if (t < 0) begin
            t = 0;
        end else if (t > 255 * one) begin
            t = 255 * one;
        end
        return 8'(t >>> FRAC_BITS);
    endfunction

    function automatic logic [7:0] adjust_channel(input logic [7:0] x);
        logic [7:0] z;
        z = stretch_channel(brighten_channel(x));
        if (invert_set) begin
            z = 8'd255 - z;
        end
        return z;
    endfunction

    function automatic pixel_t adjusted_pixel(input pixel_t px);
        pixel_t r;
        if (brightness_set == 0 && contrast_set == 0 && !invert_set) begin
            return px;
        end
        r.alpha = 8'hFF;
        r.red   = adjust_channel(px.red);
        r.green = adjust_channel(px.green);
        r.blue  = adjust_channel(px.blue);
        return r;
    endfunction

    function automatic int field_differs(input string name, input logic [7:0] want,
                                         input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge aclk) begin
        pixel_t got;
        pixel_t want;
        if (!aresetn) begin
            brightness_set = '0;
            contrast_set   = '0;
            invert_set     = 1'b0;
            factor         = FACTOR_W'(1) << FRAC_BITS;
            factor_stale   = 1'b0;
            mismatches     = 0;
            expected_pixels.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (expected_pixels.size() == 0) begin
                    $error("result transfer with no pixel outstanding: %h", m_tdata);
                    mismatches++;
                end else begin
                    want = expected_pixels.pop_front();
                    mismatches += field_differs("alpha_out", want.alpha, got.alpha);
                    mismatches += field_differs("red_out", want.red, got.red);
                    mismatches += field_differs("green_out", want.green, got.green);
                    mismatches += field_differs("blue_out", want.blue, got.blue);
                end
            end
            if (s_tvalid && s_tready) begin
                // A contrast write only takes effect once the factor is rebuilt.
                if (factor_stale) begin
                    factor       = factor_for(contrast_set);
                    factor_stale = 1'b0;
                end
                expected_pixels.push_back(adjusted_pixel(s_tdata));
            end
            if (cfg_we) begin
                case (cfg_addr)
                    REG_BRIGHTNESS: brightness_set = cfg_wdata;
                    REG_CONTRAST: begin
                        contrast_set = cfg_wdata;
                        factor_stale = 1'b1;
                    end
                    REG_INVERT: invert_set = cfg_wdata[0];
                    default: ;
                endcase
            end
        end
        in_flight = expected_pixels.size();
    end

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Top level for the pixel brightness, contrast and invert unit. It drives a
// short set of corner pixels under fixed extreme settings and then long runs
// of random pixels under random settings. Both streams get random gaps and
// stalls. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import pbci_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 2'd3;
    localparam int STALL_LIMIT    = 2000;
    localparam int RANDOM_PIXELS  = 1700;
    localparam int NUM_FIXED      = 8;

    localparam logic [31:0] CORNER_PIXELS [8] = '{
        32'h80FF_0000, 32'h7F00_FFFF, 32'hFE01_815A, 32'h00FF_7EA5,
        32'h8180_7F00, 32'hFFFF_FFFF, 32'h0000_0000, 32'h01FE_C33C
    };
    // Fixed settings: invert only, both extremes, out-of-range values,
    // single extremes and a return to neutral.
    localparam logic [7:0] FIXED_BRIGHT [NUM_FIXED] = '{
        8'h00, 8'h64, 8'h9C, 8'h7F, 8'h80, 8'h9C, 8'h00, 8'h00
    };
    localparam logic [7:0] FIXED_CONTR [NUM_FIXED] = '{
        8'h00, 8'h64, 8'h9C, 8'h80, 8'h7F, 8'h00, 8'h64, 8'h00
    };
    localparam logic FIXED_INV [NUM_FIXED] = '{
        1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0
    };

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]  cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

    int  mismatches;
    int  in_flight;
    int  quiet_cycles = 0;
    bit  steady_sender = 1'b0;

    pixel_brightness_contrast_invert_unit uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    pixel_adjust_checker pixel_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Channels lean toward the clamp edges and mid-grey.
    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            2: return 8'($urandom_range(120, 136));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] random_percent();
        case ($urandom_range(0, 9))
            0: return 8'($urandom_range(0, 255));
            1: return $urandom_range(0, 1) ? 8'h64 : 8'h9C;
            default: return 8'(int'($urandom_range(0, 200)) - 100);
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_addr  <= addr;
        cfg_wdata <= data;
        cfg_we    <= 1'b1;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic write_invert(input logic inv);
        write_reg(REG_INVERT, {7'($urandom_range(0, 127)), inv});
    endtask

    // Contrast goes last so that no write lands while the divider runs.
    task automatic apply_setting(input logic [7:0] bright, input logic [7:0] contr,
                                 input logic inv);
        write_reg(REG_BRIGHTNESS, bright);
        write_invert(inv);
        write_reg(REG_CONTRAST, contr);
    endtask

    task automatic apply_random_setting();
        if ($urandom_range(0, 7) == 0) begin
            apply_setting(8'h00, 8'h00, 1'b0);
        end else begin
            if ($urandom_range(0, 3) != 0) write_reg(REG_BRIGHTNESS, random_percent());
            if ($urandom_range(0, 2) != 0) write_invert(1'($urandom_range(0, 1)));
            if ($urandom_range(0, 9) == 0) write_reg(REG_SPARE, 8'($urandom_range(0, 255)));
            if ($urandom_range(0, 2) != 0) write_reg(REG_CONTRAST, random_percent());
        end
    endtask

    // Returns at the falling edge after the transfer with s_tvalid still high.
    task automatic send_pixel(input logic [31:0] px);
        int gap;
        gap = steady_sender ? 0 : idle_len();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= px;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (in_flight != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    // Receiver: random stalls with stretches of steady acceptance.
    initial begin
        int stall;
        int hold;
        @(posedge aresetn);
        @(negedge aclk);
        forever begin
            stall = idle_len();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            hold = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 6);
            repeat (hold) @(negedge aclk);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("pixel_brightness_contrast_invert_unit: mismatch");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int sent;
        int count;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Neutral after reset: pixels pass through with their alpha.
        for (int i = 0; i < 4; i++) send_pixel(CORNER_PIXELS[i]);
        drain();

        for (int k = 0; k < NUM_FIXED; k++) begin
            apply_setting(FIXED_BRIGHT[k], FIXED_CONTR[k], FIXED_INV[k]);
            for (int j = 0; j < 2; j++) send_pixel(CORNER_PIXELS[(2 * k + j) % 8]);
            drain();
        end

        sent = 0;
        while (sent < RANDOM_PIXELS) begin
            apply_random_setting();
            steady_sender = ($urandom_range(0, 3) == 0);
            count = $urandom_range(40, 120);
            for (int i = 0; i < count; i++) begin
                send_pixel({random_channel(), random_channel(), random_channel(),
                            8'($urandom_range(0, 255))});
            end
            sent += count;
            drain();
        end

        if (mismatches == 0) begin
            $display("pixel_brightness_contrast_invert_unit: match");
        end else begin
            $display("pixel_brightness_contrast_invert_unit: mismatch");
        end
        $finish;
    end

endmodule

// File: files.f
src/pbci_pkg.sv
src/pbci_factor_div.sv
src/pbci_lane.sv
src/pbci_merge.sv
src/pixel_brightness_contrast_invert_unit.sv
src/pbci_checker.sv
dv/pixel_adjust_checker.sv
dv/tb.sv
